// ----- hw/rtl/tctp_pkg.sv -----
// Shared types and constants for the text command parser.
`default_nettype none

package tctp_pkg;

  localparam logic [63:0] FRAME_END_WORD = 64'h434C_4F53_4544_0D0A; // "CLOSED" CR LF
  localparam logic [7:0]  COLON_CHAR     = 8'h3A;
  localparam logic [7:0]  CR_CHAR        = 8'h0D;
  localparam logic [31:0] WORD_OPEN      = 32'h6F70_656E;            // "open"
  localparam logic [39:0] WORD_CLOSE     = 40'h63_6C6F_7365;         // "close"
  localparam logic [2:0]  OPEN_LEN       = 3'd4;
  localparam logic [2:0]  CLOSE_LEN      = 3'd5;
  localparam int unsigned PAYLOAD_KEEP   = 5;
  localparam logic [2:0]  PAYLOAD_SAT    = 3'd6;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_OTHER = 2'd3
  } action_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    action_t action;
    logic    lamp;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tctp_core.sv -----
// Parse state and per-byte update logic of the text command parser.
`default_nettype none

module tctp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire tctp_pkg::item_t item,
  output tctp_pkg::result_t    result
);

  logic [63:0] recent_bytes;
  logic        colon_seen;
  logic        payload_ended;
  logic [7:0]  payload_chars [tctp_pkg::PAYLOAD_KEEP];
  logic [2:0]  payload_count;
  logic        lamp_level;

  logic [63:0] recent_next;
  logic        colon_next;
  logic        ended_next;
  logic [7:0]  chars_next [tctp_pkg::PAYLOAD_KEEP];
  logic [2:0]  count_next;
  logic        lamp_next;
  logic        clear_next;
  logic        frame_end;
  logic        is_open;
  logic        is_close;
  tctp_pkg::action_t action;

  always_comb begin
    recent_next = {recent_bytes[55:0], item.rx_byte};
    colon_next  = colon_seen;
    ended_next  = payload_ended;
    chars_next  = payload_chars;
    count_next  = payload_count;
    if (!colon_seen) begin
      colon_next = (item.rx_byte == tctp_pkg::COLON_CHAR);
    end else if (!payload_ended) begin
      if (item.rx_byte == tctp_pkg::CR_CHAR) begin
        ended_next = 1'b1;
      end else begin
        for (int i = 0; i < tctp_pkg::PAYLOAD_KEEP; i++) begin
          if (payload_count == 3'(i)) begin
            chars_next[i] = item.rx_byte;
          end
        end
        if (payload_count < tctp_pkg::PAYLOAD_SAT) begin
          count_next = payload_count + 3'd1;
        end
      end
    end

    frame_end = !item.func && (recent_next == tctp_pkg::FRAME_END_WORD);
    is_open   = colon_next && (count_next == tctp_pkg::OPEN_LEN) &&
                ({chars_next[0], chars_next[1], chars_next[2], chars_next[3]}
                 == tctp_pkg::WORD_OPEN);
    is_close  = colon_next && (count_next == tctp_pkg::CLOSE_LEN) &&
                ({chars_next[0], chars_next[1], chars_next[2], chars_next[3],
                  chars_next[4]} == tctp_pkg::WORD_CLOSE);

    lamp_next = lamp_level;
    action    = tctp_pkg::ACT_NONE;
    if (frame_end) begin
      if (is_open) begin
        lamp_next = 1'b1;
        action    = tctp_pkg::ACT_OPEN;
      end else if (is_close) begin
        lamp_next = 1'b0;
        action    = tctp_pkg::ACT_CLOSE;
      end else begin
        action    = tctp_pkg::ACT_OTHER;
      end
    end
    clear_next = item.func || frame_end;
  end

  assign result.action = action;
  assign result.lamp   = lamp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes  <= '0;
      colon_seen    <= 1'b0;
      payload_ended <= 1'b0;
      payload_count <= '0;
      lamp_level    <= 1'b0;
      for (int i = 0; i < tctp_pkg::PAYLOAD_KEEP; i++) begin
        payload_chars[i] <= '0;
      end
    end else if (fire) begin
      lamp_level <= lamp_next;
      if (clear_next) begin
        recent_bytes  <= '0;
        colon_seen    <= 1'b0;
        payload_ended <= 1'b0;
        payload_count <= '0;
        for (int i = 0; i < tctp_pkg::PAYLOAD_KEEP; i++) begin
          payload_chars[i] <= '0;
        end
      end else begin
        recent_bytes  <= recent_next;
        colon_seen    <= colon_next;
        payload_ended <= ended_next;
        payload_count <= count_next;
        payload_chars <= chars_next;
      end
    end
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && frame_end |=> !colon_seen && recent_bytes == 64'd0 && payload_count == 3'd0)
    else $error("parse state not cleared after frame end");

  a_ended_needs_colon: assert property (@(posedge clk) disable iff (rst)
    payload_ended |-> colon_seen)
    else $error("payload ended without a colon");

  a_count_needs_colon: assert property (@(posedge clk) disable iff (rst)
    payload_count != 3'd0 |-> colon_seen && payload_count <= tctp_pkg::PAYLOAD_SAT)
    else $error("payload count inconsistent");

  a_clear_keeps_lamp: assert property (@(posedge clk) disable iff (rst)
    fire && item.func |=> $stable(lamp_level))
    else $error("clear transaction changed the lamp");

endmodule

`default_nettype wire

// ----- hw/rtl/tcp_text_command_parser_unit.sv -----
// Top level of the text command parser: input register, parser, result register.
//
//  channel | dir | tdata               | tuser
//  s_*     | in  | [7:0] rx_byte       | [0] func
//  m_*     | out | [0] lamp, [7:1] 0   | [1:0] action
//
// One transaction in, one transaction out; one per cycle sustained while m_tready stays high.
// A result passes through the input register and then the result register before it is valid on m_*.
// The parse state is updated as an item moves from the input register to the result register.
// A stalled result holds the result register; one more item waits in the input register.
// Synchronous reset clears the parse state, the lamp and both register valids.
`default_nettype none

module tcp_text_command_parser_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0] s_tuser,   // [0] func
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [0] lamp, [7:1] zero
  output logic [1:0]      m_tuser    // [1:0] action
);

  logic              in_valid;
  tctp_pkg::item_t   in_item;
  logic              out_valid;
  tctp_pkg::result_t out_result;
  tctp_pkg::result_t core_result;
  logic              advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func    <= s_tuser[0];
      in_item.rx_byte <= s_tdata;
    end
  end

  tctp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_result.lamp};
  assign m_tuser  = out_result.action;

endmodule

`default_nettype wire
